@@ hw/rtl/ilm_pkg.sv @@
// Package for the indexed linked list manager: types, request codes and sizes.
// No dependencies; every other file of the block imports it.
package ilm_pkg;

  localparam int CAPACITY  = 256;
  localparam int ENTRY_W   = 8;
  localparam int COUNT_W   = 9;
  localparam int MEM_DEPTH = 2 ** ENTRY_W;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t LIST_LIMIT = count_t'((CAPACITY < 256) ? CAPACITY : 256);
  localparam count_t COUNT_ONE  = count_t'(1);

  typedef enum logic [1:0] {
    REQ_APPEND  = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_FETCH   = 2'd3
  } req_t;

  // Write side of the two link stores: one data write to each store and one
  // zero write to the next store per transfer; the zero write wins on a clash.
  typedef struct packed {
    logic   next_en;
    entry_t next_addr;
    entry_t next_data;
    logic   clr_en;
    entry_t clr_addr;
    logic   prev_en;
    entry_t prev_addr;
    entry_t prev_data;
  } link_wr_t;

  // Registered read data of both link stores at one entry.
  typedef struct packed {
    entry_t next_link;
    entry_t prev_link;
  } link_rd_t;

  typedef struct packed {
    entry_t walk_entry;
    logic   walk_done;
    count_t member_count;
  } rsp_t;

  function automatic logic entry_ok(entry_t e);
    return int'(e) < CAPACITY;
  endfunction

endpackage

@@ hw/rtl/ilm_if.sv @@
// Valid/ready channel interfaces for requests and results of the list manager.
// Depends on ilm_pkg.
interface ilm_req_if;
  import ilm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  entry_t     entry;

  modport source (output valid, output req_type, output entry, input ready);
  modport sink (input valid, input req_type, input entry, output ready);
endinterface

interface ilm_rsp_if;
  import ilm_pkg::*;
  logic   valid;
  logic   ready;
  entry_t walk_entry;
  logic   walk_done;
  count_t member_count;

  modport source (output valid, output walk_entry, output walk_done, output member_count,
                  input ready);
  modport sink (input valid, input walk_entry, input walk_done, input member_count,
                output ready);
endinterface

@@ hw/rtl/ilm_link_store.sv @@
// Next and previous link stores with a registered read at one shared address;
// the next store also takes a zero write beside its data write. Depends on ilm_pkg.
module ilm_link_store (
  input  logic              clk,
  input  logic              rd_en,
  input  ilm_pkg::entry_t   rd_addr,
  input  ilm_pkg::link_wr_t wr,
  output ilm_pkg::link_rd_t rd
);
  import ilm_pkg::*;

  entry_t next_mem [MEM_DEPTH];
  entry_t prev_mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.next_en && !(wr.clr_en && wr.clr_addr == wr.next_addr)) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.clr_en) begin
      next_mem[wr.clr_addr] <= '0;
    end
    if (wr.prev_en) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
  end

  // Forward a write of the same edge so the read sees the new link.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd.next_link <= (wr.clr_en && wr.clr_addr == rd_addr) ? '0 :
                      (wr.next_en && wr.next_addr == rd_addr) ? wr.next_data
                                                               : next_mem[rd_addr];
      rd.prev_link <= (wr.prev_en && wr.prev_addr == rd_addr) ? wr.prev_data
                                                               : prev_mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/ilm_list_state.sv @@
// Request register plus head, tail, count and walk cursor; computes the list
// update and the result for the held request. Depends on ilm_pkg.
module ilm_list_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ilm_pkg::req_t     req_type,
  input  ilm_pkg::entry_t   entry,
  input  ilm_pkg::link_rd_t rd,
  input  logic              advance,
  output logic              s1_valid,
  output ilm_pkg::entry_t   cursor_next,
  output ilm_pkg::link_wr_t wr,
  output ilm_pkg::rsp_t     result
);
  import ilm_pkg::*;

  req_t     s1_req;
  entry_t   s1_entry;
  entry_t   head, head_next;
  entry_t   tail, tail_next;
  count_t   count, count_next;
  entry_t   cursor;
  logic     ended, ended_next;
  link_wr_t wr_calc;

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    cursor_next = cursor;
    ended_next  = ended;
    wr_calc     = '0;
    result.walk_entry = '0;
    result.walk_done  = 1'b0;
    if (s1_valid) begin
      case (s1_req)
        REQ_APPEND: begin
          if (entry_ok(s1_entry) && count < LIST_LIMIT) begin
            // the new tail ends the chain; its back link is the old tail or zero
            wr_calc.clr_en    = 1'b1;
            wr_calc.clr_addr  = s1_entry;
            wr_calc.prev_en   = 1'b1;
            wr_calc.prev_addr = s1_entry;
            if (count == '0) begin
              head_next = s1_entry;
            end else begin
              wr_calc.next_en   = 1'b1;
              wr_calc.next_addr = tail;
              wr_calc.next_data = s1_entry;
              wr_calc.prev_data = tail;
            end
            tail_next  = s1_entry;
            count_next = count + COUNT_ONE;
          end
        end
        REQ_REMOVE: begin
          if (entry_ok(s1_entry) && count != '0) begin
            if (count == COUNT_ONE) begin
              head_next = '0;
              tail_next = '0;
            end else if (s1_entry == head) begin
              head_next = rd.next_link;
            end else if (s1_entry == tail) begin
              tail_next        = rd.prev_link;
              wr_calc.clr_en   = 1'b1;
              wr_calc.clr_addr = rd.prev_link;
            end else begin
              // unlink from the middle: bridge the two neighbors
              wr_calc.next_en   = 1'b1;
              wr_calc.next_addr = rd.prev_link;
              wr_calc.next_data = rd.next_link;
              wr_calc.prev_en   = 1'b1;
              wr_calc.prev_addr = rd.next_link;
              wr_calc.prev_data = rd.prev_link;
            end
            count_next = count - COUNT_ONE;
          end
        end
        REQ_RESTART: begin
          cursor_next = head;
          ended_next  = (count == '0);
        end
        REQ_FETCH: begin
          if (ended || count == '0) begin
            ended_next       = 1'b1;
            result.walk_done = 1'b1;
          end else begin
            result.walk_entry = cursor;
            if (cursor == tail) begin
              ended_next = 1'b1;
            end else begin
              cursor_next = rd.next_link;
            end
          end
        end
        default: begin
        end
      endcase
    end
    result.member_count = count_next;
  end

  always_comb begin
    wr         = wr_calc;
    wr.next_en = wr_calc.next_en & advance;
    wr.clr_en  = wr_calc.clr_en & advance;
    wr.prev_en = wr_calc.prev_en & advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      cursor   <= '0;
      ended    <= 1'b1;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        head   <= head_next;
        tail   <= tail_next;
        count  <= count_next;
        cursor <= cursor_next;
        ended  <= ended_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req   <= req_type;
      s1_entry <= entry;
    end
  end

endmodule

@@ hw/rtl/indexed_linked_list_manager_core.sv @@
// Top level of the indexed linked list manager: handshake, link stores,
// list state and result register. Depends on ilm_pkg, ilm_if, ilm_link_store,
// ilm_list_state.
//
//   channel  role  payload                              transfer when
//   -------  ----  -----------------------------------  ----------------------
//   req      sink  req_type[1:0], entry[7:0]            req.valid & req.ready
//   rsp      src   walk_entry[7:0], walk_done,          rsp.valid & rsp.ready
//                  member_count[8:0]
//
// One request per cycle sustained while rsp is ready. The link read is registered
// at the request's transfer edge; the list update and the result register load when
// the held request advances. The link stores have a single registered read port;
// writes of the previous request are forwarded. rst is synchronous; the link stores
// are not cleared, there is no clearing pass. A stalled rsp holds the result
// register and the held request; req.ready drops while a request is held.
module indexed_linked_list_manager_core (
  input logic     clk,
  input logic     rst,
  ilm_req_if.sink   req,
  ilm_rsp_if.source rsp
);
  import ilm_pkg::*;

  logic     s1_valid;
  logic     advance;
  logic     accept;
  req_t     in_req;
  entry_t   cursor_next;
  entry_t   rd_addr;
  link_wr_t wr;
  link_rd_t rd;
  rsp_t     result;

  // Advance the held request when the result register is free or draining.
  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;
  assign in_req    = req_t'(req.req_type);

  // A fetch reads the link of the cursor it will see; others read the entry.
  assign rd_addr = (in_req == REQ_FETCH) ? cursor_next : req.entry;

  ilm_link_store u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  ilm_list_state u_state (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (in_req),
    .entry       (req.entry),
    .rd          (rd),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .cursor_next (cursor_next),
    .wr          (wr),
    .result      (result)
  );

  // Result register: load on advance, drop after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.walk_entry   <= result.walk_entry;
      rsp.walk_done    <= result.walk_done;
      rsp.member_count <= result.member_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.member_count <= LIST_LIMIT)
    else $error("member count beyond list limit");

  a_done_no_entry: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.walk_done) |-> rsp.walk_entry == '0)
    else $error("walk end reported with an entry");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid)
    else $error("advanced request produced no result");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("transferred request not held");
`endif

endmodule
